// File: rtl/hlq_pkg.sv
// Shared constants for the histogram layer quantizer.
`default_nettype none
package hlq_pkg;
  localparam int GRAY_LEVELS        = 256;
  localparam int PIX_W              = 8;
  localparam int LAYER_W            = 8;
  localparam int THR_W              = 32;
  localparam int MAP_W              = PIX_W + 1;
  localparam int COUNT_BITS_DEF     = 24;
  localparam int SEARCH_ROUNDS_DEF  = 255;
  localparam logic [THR_W-1:0]   HALF_Q32    = 32'h8000_0000;
  localparam logic [THR_W-1:0]   MIN_THR_Q32 = 32'd12884902;
  localparam logic [LAYER_W-1:0] LAYER_RESET = 8'd8;
  localparam logic [PIX_W-1:0]   LEVEL_TOP   = 8'd255;
endpackage
`default_nettype wire

// File: rtl/hlq_if.sv
// Valid/ready channel interfaces for pixels, results and configuration.
`default_nettype none
interface hlq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [hlq_pkg::PIX_W-1:0] pixel_in;
  logic                      last_in;
  modport source (output valid, func, pixel_in, last_in, input ready);
  modport sink (input valid, func, pixel_in, last_in, output ready);
endinterface

interface hlq_out_if;
  logic                      valid;
  logic                      ready;
  logic [hlq_pkg::PIX_W-1:0] pixel_out;
  logic                      last_out;
  modport source (output valid, pixel_out, last_out, input ready);
  modport sink (input valid, pixel_out, last_out, output ready);
endinterface

interface hlq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [hlq_pkg::LAYER_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/histogram_layer_quantizer.sv
// Top level of the histogram layer quantizer: sequencer, search and remap.
`default_nettype none
// Histogram pass pixels (func 0) each take a read-modify-write of the level
// count RAM. The last histogram pixel starts the finishing sequence: a pass
// that builds the cumulative histogram, then per bisection round a setup step,
// a multiply step, a walk through the table RAM from the lowest to the highest
// level and an evaluate step, then one marking walk that flags the selected
// levels in the table RAM, a forward sweep and a backward sweep that build the
// remap table. Remap pixels (func 1) take one table read, then the result goes
// into the output register, where it holds until the receiver takes it. After
// reset and after every remap pixel with last_in set, a clearing pass over all
// 256 levels zeroes the level counts; no pixel is accepted meanwhile. The
// configuration channel is always ready.
module histogram_layer_quantizer #(
  parameter int COUNT_BITS    = hlq_pkg::COUNT_BITS_DEF,
  parameter int SEARCH_ROUNDS = hlq_pkg::SEARCH_ROUNDS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  hlq_in_if.sink    in_ch,
  hlq_out_if.source out_ch,
  hlq_cfg_if.sink   cfg_ch
);
  localparam int PW    = hlq_pkg::PIX_W;
  localparam int TW    = hlq_pkg::THR_W;
  localparam int TAB_W = COUNT_BITS + hlq_pkg::MAP_W + 1;
  localparam int RND_W = $clog2(SEARCH_ROUNDS + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_HST  = 4'd2;
  localparam logic [3:0] S_RMP  = 4'd3;
  localparam logic [3:0] S_CUM  = 4'd4;
  localparam logic [3:0] S_RND  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_WALK = 4'd7;
  localparam logic [3:0] S_EVAL = 4'd8;
  localparam logic [3:0] S_FWD  = 4'd9;
  localparam logic [3:0] S_BWD  = 4'd10;

  logic [3:0]              state_r, state_nxt;
  logic [7:0]              layer_r, layer_nxt;
  logic [PW-1:0]           lowest_r, lowest_nxt, highest_r, highest_nxt;
  logic [PW:0]             idx_r, idx_nxt;
  logic [PW-1:0]           pix_r, pix_nxt;
  logic                    last_r, last_nxt;
  logic [COUNT_BITS-1:0]   acc_r, acc_nxt;
  logic                    pv_r, pv_nxt;
  logic [PW-1:0]           pidx_r, pidx_nxt;
  logic [TW-1:0]           thr_r, thr_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [RND_W-1:0]        round_r, round_nxt;
  logic [TW+COUNT_BITS-1:0] rhs_r, rhs_nxt;
  logic [COUNT_BITS-1:0]   base_r, base_nxt;
  logic [PW:0]             found_r, found_nxt;
  logic                    mark_r, mark_nxt;
  logic                    lv_r, lv_nxt, hv_r, hv_nxt;
  logic [PW-1:0]           lvl_r, lvl_nxt, hvl_r, hvl_nxt;
  logic                    have_map_r, have_map_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [PW-1:0]           out_pix_r, out_pix_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    cnt_we, cnt_re, tab_we, tab_re;
  logic [PW-1:0]           cnt_waddr, cnt_raddr, tab_waddr, tab_raddr;
  logic [COUNT_BITS-1:0]   cnt_wdata, cnt_rdata;
  logic [TAB_W-1:0]        tab_wdata, tab_rdata;

  logic [COUNT_BITS:0]     cum_sum;
  logic [COUNT_BITS-1:0]   cum_q, diff;
  logic [TW:0]             mid_lo, mid_hi;
  logic signed [9:0]       target, found_s;
  logic                    issue, hv_e, lov, sel_q;
  logic [PW-1:0]           hval_e, lo_val, near;

  hlq_ram #(.WIDTH(COUNT_BITS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  // Table RAM: cumulative counts in the low bits; above them the remap entry
  // {valid, level}, and the selected flag in the top bit.
  hlq_ram #(.WIDTH(TAB_W)) u_tab_ram (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .re(tab_re), .raddr(tab_raddr), .rdata(tab_rdata)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_pix_r;
  assign out_ch.last_out  = out_last_r;

  assign cum_q   = tab_rdata[COUNT_BITS-1:0];
  assign diff    = cum_q - base_r;
  assign cum_sum = {1'b0, acc_r} + {1'b0, cnt_rdata};
  assign mid_lo  = ({1'b0, lo_r} + {1'b0, thr_r}) >> 1;
  assign mid_hi  = ({1'b0, hi_r} + {1'b0, thr_r}) >> 1;
  assign target  = $signed({2'b00, layer_r}) - 10'sd1;
  assign found_s = $signed({1'b0, found_r});
  assign sel_q   = tab_rdata[TAB_W-1];
  assign lov     = tab_rdata[TAB_W-2];
  assign lo_val  = tab_rdata[COUNT_BITS+PW-1:COUNT_BITS];
  assign hv_e    = sel_q | hv_r;
  assign hval_e  = sel_q ? pidx_r : hvl_r;

  // Nearest selected level, lower one on a tie.
  always_comb begin
    if (lov && hv_e) begin
      near = ((pidx_r - lo_val) <= (hval_e - pidx_r)) ? lo_val : hval_e;
    end else if (lov) begin
      near = lo_val;
    end else if (hv_e) begin
      near = hval_e;
    end else begin
      near = pidx_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    layer_nxt     = layer_r;
    lowest_nxt    = lowest_r;
    highest_nxt   = highest_r;
    idx_nxt       = idx_r;
    pix_nxt       = pix_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = idx_r[PW-1:0];
    thr_nxt       = thr_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    round_nxt     = round_r;
    rhs_nxt       = rhs_r;
    base_nxt      = base_r;
    found_nxt     = found_r;
    mark_nxt      = mark_r;
    lv_nxt        = lv_r;
    lvl_nxt       = lvl_r;
    hv_nxt        = hv_r;
    hvl_nxt       = hvl_r;
    have_map_nxt  = have_map_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pix_nxt   = out_pix_r;
    out_last_nxt  = out_last_r;
    cnt_we        = 1'b0;
    cnt_waddr     = pix_r;
    cnt_wdata     = '0;
    cnt_re        = 1'b0;
    cnt_raddr     = idx_r[PW-1:0];
    tab_we        = 1'b0;
    tab_waddr     = pidx_r;
    tab_wdata     = '0;
    tab_re        = 1'b0;
    tab_raddr     = idx_r[PW-1:0];
    issue         = 1'b0;

    if (cfg_ch.valid) begin
      layer_nxt = cfg_ch.data;
    end

    case (state_r)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = idx_r[PW-1:0];
        idx_nxt   = idx_r + 1'b1;
        if (idx_r[PW-1:0] == hlq_pkg::LEVEL_TOP) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          pix_nxt  = in_ch.pixel_in;
          last_nxt = in_ch.last_in;
          if (!in_ch.func) begin
            cnt_re    = 1'b1;
            cnt_raddr = in_ch.pixel_in;
            if (in_ch.pixel_in < lowest_r) begin
              lowest_nxt = in_ch.pixel_in;
            end
            if (in_ch.pixel_in > highest_r) begin
              highest_nxt = in_ch.pixel_in;
            end
            state_nxt = S_HST;
          end else begin
            tab_re    = 1'b1;
            tab_raddr = in_ch.pixel_in;
            state_nxt = S_RMP;
          end
        end
      end
      S_HST: begin
        // Saturating increment; write back the count read last cycle.
        cnt_we    = 1'b1;
        cnt_wdata = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
        if (last_r) begin
          idx_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_CUM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RMP: begin
        // Hold the read data until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = have_map_r ? lo_val : pix_r;
          out_last_nxt  = last_r;
          if (last_r) begin
            idx_nxt     = '0;
            lowest_nxt  = hlq_pkg::LEVEL_TOP;
            highest_nxt = '0;
            state_nxt   = S_CLR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CUM: begin
        // Also drop every selected flag and remap entry of the previous image.
        issue  = !idx_r[PW];
        cnt_re = issue;
        pv_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pv_r) begin
          acc_nxt   = cum_sum[COUNT_BITS] ? CNT_MAX : cum_sum[COUNT_BITS-1:0];
          tab_we    = 1'b1;
          tab_wdata = {{(hlq_pkg::MAP_W + 1){1'b0}}, acc_nxt};
          if (pidx_r == hlq_pkg::LEVEL_TOP) begin
            thr_nxt   = hlq_pkg::HALF_Q32;
            lo_nxt    = '0;
            hi_nxt    = hlq_pkg::HALF_Q32;
            round_nxt = '0;
            mark_nxt  = 1'b0;
            state_nxt = S_RND;
          end
        end
      end
      S_RND: begin
        // Stop on a tiny threshold or after the round limit, then mark.
        if (thr_r < hlq_pkg::MIN_THR_Q32 || round_r == RND_W'(SEARCH_ROUNDS)) begin
          mark_nxt = 1'b1;
        end
        idx_nxt   = {1'b0, lowest_r};
        found_nxt = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        rhs_nxt   = thr_r * acc_r;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        issue  = (idx_r <= {1'b0, highest_r});
        tab_re = issue;
        pv_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pv_r) begin
          // On the marking walk, flag the lowest level and every step taken.
          tab_wdata = {1'b1, {hlq_pkg::MAP_W{1'b0}}, cum_q};
          if (pidx_r == lowest_r) begin
            base_nxt = cum_q;
            tab_we   = mark_r;
          end else if ({diff, {TW{1'b0}}} > rhs_r) begin
            base_nxt  = cum_q;
            found_nxt = found_r + 1'b1;
            tab_we    = mark_r;
          end
        end
        if (!issue && !pv_r) begin
          if (mark_r) begin
            idx_nxt   = '0;
            lv_nxt    = 1'b0;
            state_nxt = S_FWD;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        round_nxt = round_r + 1'b1;
        state_nxt = S_RND;
        if (found_s < target) begin
          hi_nxt  = thr_r;
          thr_nxt = mid_lo[TW-1:0];
        end else if (found_s > target) begin
          lo_nxt  = thr_r;
          thr_nxt = mid_hi[TW-1:0];
        end else begin
          round_nxt = round_r;
          mark_nxt  = 1'b1;
          idx_nxt   = {1'b0, lowest_r};
          found_nxt = '0;
          state_nxt = S_MUL;
        end
      end
      S_FWD: begin
        // Store the nearest selected level at or below each entry.
        issue  = !idx_r[PW];
        tab_re = issue;
        pv_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pv_r) begin
          if (sel_q) begin
            lv_nxt  = 1'b1;
            lvl_nxt = pidx_r;
          end
          tab_we    = 1'b1;
          tab_wdata = {sel_q, lv_nxt, lvl_nxt, {COUNT_BITS{1'b0}}};
        end
        if (!issue && !pv_r) begin
          idx_nxt   = {1'b0, hlq_pkg::LEVEL_TOP};
          hv_nxt    = 1'b0;
          state_nxt = S_BWD;
        end
      end
      S_BWD: begin
        // Walk down, fold in the nearest level above, write the final map.
        issue  = !idx_r[PW];
        tab_re = issue;
        pv_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r - 1'b1;
        end
        if (pv_r) begin
          hv_nxt    = hv_e;
          hvl_nxt   = hval_e;
          tab_we    = 1'b1;
          tab_wdata = {sel_q, 1'b1, near, {COUNT_BITS{1'b0}}};
        end
        if (!issue && !pv_r) begin
          have_map_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      layer_r     <= hlq_pkg::LAYER_RESET;
      lowest_r    <= hlq_pkg::LEVEL_TOP;
      highest_r   <= '0;
      pv_r        <= 1'b0;
      thr_r       <= hlq_pkg::HALF_Q32;
      lo_r        <= '0;
      hi_r        <= hlq_pkg::HALF_Q32;
      round_r     <= '0;
      mark_r      <= 1'b0;
      have_map_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      layer_r     <= layer_nxt;
      lowest_r    <= lowest_nxt;
      highest_r   <= highest_nxt;
      pv_r        <= pv_nxt;
      thr_r       <= thr_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      round_r     <= round_nxt;
      mark_r      <= mark_nxt;
      have_map_r  <= have_map_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    last_r     <= last_nxt;
    acc_r      <= acc_nxt;
    pidx_r     <= pidx_nxt;
    rhs_r      <= rhs_nxt;
    base_r     <= base_nxt;
    found_r    <= found_nxt;
    lv_r       <= lv_nxt;
    lvl_r      <= lvl_nxt;
    hv_r       <= hv_nxt;
    hvl_r      <= hvl_nxt;
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef NO_ASSERTIONS
  a_range_after_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HST) |-> (lowest_r <= highest_r))
    else $error("level range inverted after histogram pixel");

  a_thr_bracketed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (lo_r <= thr_r && thr_r <= hi_r))
    else $error("threshold left its search bracket");

  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (found_r <= {1'b0, highest_r - lowest_r}))
    else $error("walk found more levels than the range holds");

  a_result_from_remap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RMP))
    else $error("result produced outside a remap transfer");
`endif
endmodule
`default_nettype wire

// File: rtl/hlq_ram.sv
// Single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module hlq_ram #(
  parameter int WIDTH = hlq_pkg::COUNT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [hlq_pkg::PIX_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic                      re,
  input  wire logic [hlq_pkg::PIX_W-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);
  logic [WIDTH-1:0] mem [hlq_pkg::GRAY_LEVELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire
